// ----- design/slx_pkg.sv -----
// Shared types and constants for the sigmoid_limit_exp block.
// No dependencies.
package slx_pkg;

  // Field widths
  localparam int XW   = 16;   // sample, signed Q5.10
  localparam int YW   = 16;   // result, unsigned Q1.15
  localparam int LIMW = 15;   // clamp magnitude, Q5.10
  localparam int QW   = 48;   // working value, unsigned Q16.32
  localparam int DW   = 49;   // reciprocal divisor and remainder width
  localparam int QBITS = 16;  // quotient bits

  // Configuration port
  localparam int PAW = 3;
  localparam int PDW = 32;
  localparam logic REG_CLAMP_LIMIT = 1'b0;     // register index, paddr[2]
  localparam logic [LIMW-1:0] CLAMP_RESET = 15'd30720;

  localparam int SQUARINGS_DEF = 10;

  // Word handed from front to back through the queue, and between squarings
  typedef struct packed {
    logic          ok;    // no saturation so far
    logic [QW-1:0] val;   // Q16.32
  } sq_word_t;

endpackage

// ----- design/slx_front.sv -----
// Front end: clamps a sample and forms the Q16.32 base 1 - x/1024.
// Depends on slx_pkg.
module slx_front import slx_pkg::*; (
  input  logic [XW-1:0]   x_in_i,
  input  logic [LIMW-1:0] clamp_limit_i,
  output sq_word_t        word_o
);

  logic signed [XW:0]   x_s;
  logic signed [XW:0]   lim_s;
  logic signed [XW:0]   xc;
  logic signed [DW-1:0] base;

  // Clamp to the symmetric limit
  always_comb begin
    x_s   = {x_in_i[XW-1], x_in_i};
    lim_s = {2'b00, clamp_limit_i};
    xc    = x_s;
    if (x_s > lim_s) begin
      xc = lim_s;
    end
    if (x_s < -lim_s) begin
      xc = -lim_s;
    end
  end

  // Base = 2^32 - xc * 2^12, always positive and below 2^33
  always_comb begin
    base = (DW'(1) <<< 32) - {{(DW-XW-13){xc[XW]}}, xc, 12'b0};
    word_o.ok  = 1'b1;
    word_o.val = base[QW-1:0];
  end

endmodule

// ----- design/slx_fifo.sv -----
// Two-entry queue between the front and the back end.
// Depends on slx_pkg.
module slx_fifo import slx_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  sq_word_t word_i,
  input  logic     pop_i,
  output sq_word_t word_o,
  output logic     empty_o,
  output logic     full_o
);

  sq_word_t   mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign word_o  = mem_q[rptr_q];

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= word_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- design/slx_back.sv -----
// Back end: SQUARINGS two-stage squaring steps, then a 16-stage
// restoring divider for 2^15/(1+e) rounded. Depends on slx_pkg.
module slx_back import slx_pkg::*; #(
  parameter int SQUARINGS = SQUARINGS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  sq_word_t      word_i,
  output logic          y_valid_o,
  output logic [YW-1:0] y_out_o
);

  localparam int HW = QW / 2 - 4;  // 20-bit halves of a 40-bit operand

  // Squaring pipeline
  logic            sa_v_q  [SQUARINGS];
  logic            sa_ok_q [SQUARINGS];
  logic [2*HW-1:0] hh_q    [SQUARINGS];
  logic [2*HW-1:0] hl_q    [SQUARINGS];
  logic [2*HW-1:0] ll_q    [SQUARINGS];
  logic            sb_v_q  [SQUARINGS];
  sq_word_t        sb_q    [SQUARINGS];

  for (genvar s = 0; s < SQUARINGS; s++) begin : g_sq
    logic       in_v;
    sq_word_t   in_w;
    logic [HW-1:0] ah, al;
    logic [4*HW:0] sum;

    if (s == 0) begin : g_first
      assign in_v = valid_i;
      assign in_w = word_i;
    end else begin : g_next
      assign in_v = sb_v_q[s-1];
      assign in_w = sb_q[s-1];
    end

    assign ah = in_w.val[2*HW-1:HW];
    assign al = in_w.val[HW-1:0];

    // Form partial products; a value of 2^40 or more already saturates
    always_ff @(posedge clk_i) begin
      sa_ok_q[s] <= in_w.ok && (in_w.val[QW-1:2*HW] == '0);
      hh_q[s]    <= ah * ah;
      hl_q[s]    <= ah * al;
      ll_q[s]    <= al * al;
    end

    // Sum, round half up, drop 32 fraction bits, check the Q16.32 range
    assign sum = {1'b0, hh_q[s], {(2*HW){1'b0}}}
               + {{HW{1'b0}}, hl_q[s], {(HW+1){1'b0}}}
               + {{(2*HW+1){1'b0}}, ll_q[s]}
               + ((4*HW+1)'(1) << 31);

    always_ff @(posedge clk_i) begin
      sb_q[s].ok  <= sa_ok_q[s] && !sum[4*HW];
      sb_q[s].val <= sum[4*HW-1:32];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sa_v_q[s] <= 1'b0;
        sb_v_q[s] <= 1'b0;
      end else begin
        sa_v_q[s] <= in_v;
        sb_v_q[s] <= sa_v_q[s];
      end
    end
  end

  // Prepare divisor d = 2^32 + e and numerator 2^47 + d/2
  logic          pv_q, pok_q;
  logic [DW-1:0] pd_q, pn_q;
  logic [DW-1:0] d_c;

  assign d_c = {1'b0, sb_q[SQUARINGS-1].val} + (DW'(1) << 32);

  always_ff @(posedge clk_i) begin
    pok_q <= sb_q[SQUARINGS-1].ok;
    pd_q  <= d_c;
    pn_q  <= (DW'(1) << 47) + {1'b0, d_c[DW-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= sb_v_q[SQUARINGS-1];
    end
  end

  // Restoring division, one quotient bit per stage
  logic             dv_q  [QBITS];
  logic             dok_q [QBITS];
  logic [DW-1:0]    dd_q  [QBITS];
  logic [DW-1:0]    dr_q  [QBITS];
  logic [QBITS-1:0] dq_q  [QBITS];

  for (genvar k = 0; k < QBITS; k++) begin : g_div
    localparam int BIT = QBITS - 1 - k;
    logic                in_v, in_ok;
    logic [DW-1:0]       in_d, in_r;
    logic [QBITS-1:0]    in_q;
    logic [DW+QBITS-1:0] dsh;
    logic                take;

    if (k == 0) begin : g_first
      assign in_v  = pv_q;
      assign in_ok = pok_q;
      assign in_d  = pd_q;
      assign in_r  = pn_q;
      assign in_q  = '0;
    end else begin : g_next
      assign in_v  = dv_q[k-1];
      assign in_ok = dok_q[k-1];
      assign in_d  = dd_q[k-1];
      assign in_r  = dr_q[k-1];
      assign in_q  = dq_q[k-1];
    end

    assign dsh  = {{QBITS{1'b0}}, in_d} << BIT;
    assign take = {{QBITS{1'b0}}, in_r} >= dsh;

    always_ff @(posedge clk_i) begin
      dok_q[k] <= in_ok;
      dd_q[k]  <= in_d;
      dr_q[k]  <= take ? (in_r - dsh[DW-1:0]) : in_r;
      dq_q[k]  <= in_q | (take ? (QBITS'(1) << BIT) : '0);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else begin
        dv_q[k] <= in_v;
      end
    end
  end

  // Output register; saturation forces zero
  logic          y_valid_q;
  logic [YW-1:0] y_out_q;

  always_ff @(posedge clk_i) begin
    y_out_q <= dok_q[QBITS-1] ? dq_q[QBITS-1] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_valid_q <= 1'b0;
    end else begin
      y_valid_q <= dv_q[QBITS-1];
    end
  end

  assign y_valid_o = y_valid_q;
  assign y_out_o   = y_out_q;

endmodule

// ----- design/sigmoid_limit_exp.sv -----
// Top level of the logistic sigmoid block: config register, front, queue, back.
// Depends on slx_pkg, slx_front, slx_fifo, slx_back.
//
// One word is taken per clock cycle (start high, busy low) and its Q1.15
// sigmoid appears on y_out_o with y_valid_o high for one cycle. A word passes
// through the queue stage, the squaring chain (two stages per squaring:
// partial products, then sum and round), one divisor prep stage, the
// 16-stage divider (one quotient bit per stage) and the output register. The
// result cannot be held off; every word flows straight through, so busy stays
// low.
module sigmoid_limit_exp import slx_pkg::*; #(
  parameter int SQUARINGS = SQUARINGS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  logic [XW-1:0]  x_in_i,
  output logic           y_valid_o,
  output logic [YW-1:0]  y_out_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [PAW-1:0] paddr,
  input  logic [PDW-1:0] pwdata,
  output logic [PDW-1:0] prdata,
  output logic           pready
);

  logic [LIMW-1:0] clamp_limit_q;
  sq_word_t        front_word, q_word;
  logic            q_empty, q_full, accept;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CLAMP_LIMIT) ? {{(PDW-LIMW){1'b0}}, clamp_limit_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_limit_q <= CLAMP_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_CLAMP_LIMIT)) begin
      clamp_limit_q <= pwdata[LIMW-1:0];
    end
  end

  assign busy   = q_full;
  assign accept = start && !busy;

  slx_front u_front (
    .x_in_i        (x_in_i),
    .clamp_limit_i (clamp_limit_q),
    .word_o        (front_word)
  );

  slx_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .word_i  (front_word),
    .pop_i   (!q_empty),
    .word_o  (q_word),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  slx_back #(.SQUARINGS(SQUARINGS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (!q_empty),
    .word_i    (q_word),
    .y_valid_o (y_valid_o),
    .y_out_o   (y_out_o)
  );

  // The back end drains every cycle, so the queue never fills
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("queue filled");

  // Every accepted word yields a strobe after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(2*SQUARINGS+19) y_valid_o)
    else $error("result strobe missing");

  // Sigmoid never exceeds 1.0
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    y_valid_o |-> (y_out_o <= 16'd32768))
    else $error("result out of range");

endmodule

// ----- tb/sv/sigmoid_limit_exp_test.sv -----
// Self-checking bench for sigmoid_limit_exp: directed table, then random words.
// Depends on slx_pkg and the sigmoid_limit_exp RTL; needs nothing else.
module sigmoid_limit_exp_test;
  import slx_pkg::*;

  localparam int  LATENCY   = 2 * SQUARINGS_DEF + 19;
  localparam int  CYCLE_CAP = 400000;
  localparam logic REG_SPARE = 1'b1;  // index past the last register
  localparam logic [127:0] Q48_TOP = (128'd1 << 48) - 1;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  logic [XW-1:0]  x_in_i = '0;
  logic           y_valid_o;
  logic [YW-1:0]  y_out_o;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [PAW-1:0] paddr = '0;
  logic [PDW-1:0] pwdata = '0;
  logic [PDW-1:0] prdata;
  logic           pready;

  int             pinned_y = -1;   // typed expectation for the word on x_in_i
  logic [LIMW-1:0] clamp_mirror;
  logic [YW-1:0]  y_expected[$];
  int             fails = 0;
  int             words_sent = 0;
  int             words_seen = 0;
  int             writes_done = 0;
  int             cycles = 0;

  sigmoid_limit_exp i_dut (
    .clk_i, .rst_ni, .start, .busy, .x_in_i, .y_valid_o, .y_out_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Sigmoid of one sample: clamp, square the base, take the rounded reciprocal
  function automatic logic [YW-1:0] sigmoid_q15(input logic [XW-1:0] x,
                                                 input logic [LIMW-1:0] lim);
    longint       xc;
    longint       lm;
    logic [127:0] e;
    logic [127:0] hi;
    logic [127:0] lo;
    logic [127:0] r;
    logic [127:0] d;
    logic [127:0] y;
    bit           ok;
    xc = longint'($signed(x));
    lm = longint'(lim);
    if (xc > lm) xc = lm;
    if (xc < -lm) xc = -lm;
    e = 128'((longint'(1) << 32) - xc * 4096);
    ok = 1'b1;
    for (int k = 0; k < SQUARINGS_DEF; k++) begin
      if (ok) begin
        hi = e >> 32;
        lo = e & 128'hFFFF_FFFF;
        if (hi >= 256) begin
          e = Q48_TOP;
          ok = 1'b0;
        end else begin
          r = ((hi * hi) << 32) + 2 * hi * lo + ((lo * lo + 128'h8000_0000) >> 32);
          if (r > Q48_TOP) begin
            e = Q48_TOP;
            ok = 1'b0;
          end else begin
            e = r;
          end
        end
      end
    end
    if (!ok) return '0;
    d = (128'd1 << 32) + e;
    y = ((128'd1 << 47) + (d >> 1)) / d;
    return y[YW-1:0];
  endfunction

  task automatic report(input string what, input logic [YW-1:0] got,
                        input logic [YW-1:0] want);
    fails++;
    $display("ERROR %s: y_out got %0d want %0d (cycle %0d)", what, got, want, cycles);
  endtask

  // Track register writes, queue expectations, check each result word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (psel && penable && pwrite && pready) begin
        writes_done++;
        if (paddr[2] == REG_CLAMP_LIMIT) clamp_mirror = pwdata[LIMW-1:0];
      end
      if (start && !busy) begin
        if (pinned_y >= 0) y_expected.push_back(pinned_y[YW-1:0]);
        else y_expected.push_back(sigmoid_q15(x_in_i, clamp_mirror));
      end
      if (y_valid_o) begin
        words_seen++;
        if (y_expected.size() == 0) report("unexpected word", y_out_o, '0);
        else begin
          logic [YW-1:0] want;
          want = y_expected.pop_front();
          if (y_out_o !== want) report("mismatch", y_out_o, want);
        end
      end
    end
  end

  // Drop the run at the cycle cap
  always @(posedge clk_i) begin
    if (cycles >= CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               y_expected.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Hold start low for a random gap, mostly short, sometimes long
  task automatic idle_gap();
    int roll;
    int gap;
    roll = $urandom_range(0, 99);
    if (roll < 65) gap = 0;
    else if (roll < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Present one word and wait for the accepting edge
  task automatic send_word(input logic [XW-1:0] x, input int pin);
    start <= 1'b1;
    x_in_i <= x;
    pinned_y <= pin;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    words_sent++;
    idle_gap();
  endtask

  // Wait for every outstanding word, then let the pipeline settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (y_expected.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic idx, input logic [PDW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Random sample: full range, near zero, hugging the clamp, or full scale
  function automatic logic [XW-1:0] pick_sample(input logic [LIMW-1:0] lim);
    int roll;
    int v;
    roll = $urandom_range(0, 99);
    if (roll < 35) return XW'($urandom);
    if (roll < 65) return XW'($urandom_range(0, 8192) - 4096);
    if (roll < 85) begin
      v = int'(lim) + $urandom_range(0, 16) - 8;
      if ($urandom_range(0, 1)) v = -v;
      return XW'(v);
    end
    return XW'($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000);
  endfunction

  typedef struct {
    logic [XW-1:0] x;
    int            y;   // -1: take the predictor
  } table_row_t;

  table_row_t dir_rows[] = '{
    '{16'h0000, 16384}, '{16'h7FFF, 32768}, '{16'h8000, 0},
    '{16'h0001, -1}, '{16'hFFFF, -1}, '{16'h0400, -1}, '{16'hFC00, -1},
    '{16'h7800, 32768}, '{16'h8800, 0}, '{16'h7801, 32768}, '{16'h87FF, 0},
    '{16'h1000, -1}, '{16'hF000, -1}, '{16'h0200, -1}, '{16'hFE00, -1},
    '{16'h2AAA, -1}, '{16'hD555, -1}, '{16'h5555, -1}, '{16'hAAAA, -1},
    '{16'h00FF, -1}, '{16'hFF00, -1}
  };

  logic [PDW-1:0] phase_limits[6] = '{32'hFFFF_8000, 32'h0000_7FFF, 32'hA5A5_0400,
                                      32'h0000_0001, 32'h5A5A_7800, 32'h0000_1ABC};

  initial begin
    clamp_mirror = CLAMP_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows at the reset clamp
    foreach (dir_rows[i]) send_word(dir_rows[i].x, dir_rows[i].y);
    drain();

    // Zero clamp: every sample reads as 0
    apb_write(REG_CLAMP_LIMIT, 32'h0000_0000);
    apb_write(REG_SPARE, 32'hFFFF_FFFF);
    send_word(16'h7FFF, 16384);
    send_word(16'h8000, 16384);
    send_word(16'h1234, 16384);

    // Random phases, one clamp setting each
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      if (ph == 3) apb_write(REG_SPARE, 32'h0000_0000);
      apb_write(REG_CLAMP_LIMIT, phase_limits[ph]);
      @(posedge clk_i);
      for (int n = 0; n < 300; n++) begin
        send_word(pick_sample(clamp_mirror), -1);
        if (n == 150) drain();
      end
    end
    drain();

    if (y_expected.size() != 0) report("words never arrived", '0, y_expected[0]);
    $display("covered %0d words, %0d results, %0d register writes over six clamp settings",
             words_sent, words_seen, writes_done);
    $display("clamp extremes 0 and 32767, saturation, full-scale and stall gaps included");
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/slx_pkg.sv
design/slx_front.sv
design/slx_fifo.sv
design/slx_back.sv
design/sigmoid_limit_exp.sv
tb/sv/sigmoid_limit_exp_test.sv
